### rtl/akd_pkg.sv
package akd_pkg;

    localparam int LIMIT_W    = 12;
    localparam int SPG_W      = 8;
    localparam int SETTLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int CLS_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CLS_W-1:0] cls_t;

    localparam cls_t CLS_NONE   = 3'd0;
    localparam cls_t CLS_RIGHT  = 3'd1;
    localparam cls_t CLS_UP     = 3'd2;
    localparam cls_t CLS_DOWN   = 3'd3;
    localparam cls_t CLS_LEFT   = 3'd4;
    localparam cls_t CLS_SELECT = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SPG    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd6;

    localparam logic [SPG_W-1:0]    RST_SPG    = 8'd5;
    localparam logic [LIMIT_W-1:0]  RST_RIGHT  = 12'd200;
    localparam logic [LIMIT_W-1:0]  RST_UP     = 12'd1800;
    localparam logic [LIMIT_W-1:0]  RST_DOWN   = 12'd3200;
    localparam logic [LIMIT_W-1:0]  RST_LEFT   = 12'd3800;
    localparam logic [LIMIT_W-1:0]  RST_SELECT = 12'd4090;
    localparam logic [SETTLE_W-1:0] RST_SETTLE = 16'd40;

    typedef struct packed {
        logic [LIMIT_W-1:0]  right_limit;
        logic [LIMIT_W-1:0]  up_limit;
        logic [LIMIT_W-1:0]  down_limit;
        logic [LIMIT_W-1:0]  left_limit;
        logic [LIMIT_W-1:0]  select_limit;
        logic [SETTLE_W-1:0] settle_ms;
    } cls_cfg_t;

endpackage

### rtl/akd_front.sv
module akd_front #(
    parameter int ADC_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [akd_pkg::SPG_W-1:0]    samples_per_group,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ADC_BITS-1:0]          sample,
    input  logic [akd_pkg::TIME_W-1:0]   now_ms,
    output logic                         grp_push,
    input  logic                         grp_full,
    output logic [ADC_BITS+akd_pkg::SPG_W-1:0] grp_sum,
    output logic [akd_pkg::SPG_W-1:0]    grp_count,
    output logic [akd_pkg::TIME_W-1:0]   grp_time
);
    import akd_pkg::*;

    localparam int SUM_W = ADC_BITS + SPG_W;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SPG_W-1:0] taken_reg, taken_next;
    logic [SUM_W-1:0] sum_add;
    logic [SPG_W:0]   count_w;
    logic [SPG_W:0]   target;
    logic             accept;
    logic             complete;

    assign in_ready = !grp_full;
    assign accept   = in_valid && in_ready;
    assign sum_add  = sum_reg + SUM_W'(sample);
    assign count_w  = {1'b0, taken_reg} + 1'b1;
    // a group size of zero behaves as one
    assign target   = (samples_per_group == '0) ? (SPG_W+1)'(1)
                                                : {1'b0, samples_per_group};
    assign complete = count_w >= target;

    assign grp_push  = accept && complete;
    assign grp_sum   = sum_add;
    assign grp_count = count_w[SPG_W-1:0];
    assign grp_time  = now_ms;

    always_comb
    begin
        sum_next   = sum_reg;
        taken_next = taken_reg;
        if (accept)
        begin
            if (complete)
            begin
                sum_next   = '0;
                taken_next = '0;
            end
            else
            begin
                sum_next   = sum_add;
                taken_next = count_w[SPG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            taken_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            taken_reg <= taken_next;
        end
    end

endmodule

### rtl/akd_fifo.sv
module akd_fifo #(
    parameter int WIDTH = 60
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full  = cnt_reg == (PTR_W+1)'(DEPTH);
    assign empty = cnt_reg == '0;
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/akd_back.sv
module akd_back #(
    parameter int ADC_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  akd_pkg::cls_cfg_t                 cfg,
    input  logic                              grp_empty,
    output logic                              grp_pop,
    input  logic [ADC_BITS+akd_pkg::SPG_W-1:0] grp_sum,
    input  logic [akd_pkg::SPG_W-1:0]         grp_count,
    input  logic [akd_pkg::TIME_W-1:0]        grp_time,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ADC_BITS-1:0]               average,
    output akd_pkg::cls_t                     level,
    output akd_pkg::cls_t                     press_event
);
    import akd_pkg::*;

    localparam int SUM_W  = ADC_BITS + SPG_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int CMP_W  = (ADC_BITS > LIMIT_W) ? ADC_BITS : LIMIT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [SPG_W-1:0]  rem_reg, rem_next;
    logic [SPG_W-1:0]  dvs_reg, dvs_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [STEP_W-1:0] step_reg, step_next;

    cls_t              stable_reg, stable_next;
    cls_t              reported_reg, reported_next;
    logic [TIME_W-1:0] change_reg, change_next;

    logic              ov_reg, ov_next;
    logic [ADC_BITS-1:0] avg_reg, avg_next;
    cls_t              lvl_reg, lvl_next;
    cls_t              press_reg, press_next;

    logic [SPG_W:0]    rem_sh;
    logic [SPG_W:0]    rem_diff;
    logic              qbit;
    logic [ADC_BITS-1:0] quot;
    logic [CMP_W-1:0]  avg_ext;
    cls_t              cls;
    logic [TIME_W-1:0] elapsed;
    logic              settled;
    logic              emit;

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign qbit     = rem_sh >= {1'b0, dvs_reg};
    assign quot     = dvd_reg[ADC_BITS-1:0];
    assign avg_ext  = CMP_W'(quot);

    always_comb
    begin
        priority if (avg_ext < CMP_W'(cfg.right_limit))
            cls = CLS_RIGHT;
        else if (avg_ext < CMP_W'(cfg.up_limit))
            cls = CLS_UP;
        else if (avg_ext < CMP_W'(cfg.down_limit))
            cls = CLS_DOWN;
        else if (avg_ext < CMP_W'(cfg.left_limit))
            cls = CLS_LEFT;
        else if (avg_ext < CMP_W'(cfg.select_limit))
            cls = CLS_SELECT;
        else
            cls = CLS_NONE;
    end

    assign elapsed = t_reg - change_reg;
    assign settled = elapsed >= TIME_W'(cfg.settle_ms);
    assign emit    = (state_reg == ST_DONE) && (!ov_reg || out_ready);
    assign grp_pop = (state_reg == ST_IDLE) && !grp_empty;

    always_comb
    begin
        state_next    = state_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        t_next        = t_reg;
        step_next     = step_reg;
        stable_next   = stable_reg;
        reported_next = reported_reg;
        change_next   = change_reg;
        ov_next       = ov_reg;
        avg_next      = avg_reg;
        lvl_next      = lvl_reg;
        press_next    = press_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!grp_empty)
                begin
                    dvd_next   = grp_sum;
                    dvs_next   = grp_count;
                    t_next     = grp_time;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                dvd_next  = {dvd_reg[SUM_W-2:0], qbit};
                rem_next  = qbit ? rem_diff[SPG_W-1:0] : rem_sh[SPG_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (emit)
                begin
                    ov_next    = 1'b1;
                    avg_next   = quot;
                    lvl_next   = cls;
                    press_next = CLS_NONE;
                    if (cls != stable_reg)
                    begin
                        stable_next = cls;
                        change_next = t_reg;
                    end
                    else if (settled)
                    begin
                        if (stable_reg != CLS_NONE && reported_reg == CLS_NONE)
                        begin
                            press_next = stable_reg;
                        end
                        reported_next = stable_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            stable_reg   <= CLS_NONE;
            reported_reg <= CLS_NONE;
            change_reg   <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            stable_reg   <= stable_next;
            reported_reg <= reported_next;
            change_reg   <= change_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        t_reg     <= t_next;
        avg_reg   <= avg_next;
        lvl_reg   <= lvl_next;
        press_reg <= press_next;
    end

    assign out_valid   = ov_reg;
    assign average     = avg_reg;
    assign level       = lvl_reg;
    assign press_event = press_reg;

endmodule

### rtl/adc_ladder_keypad_decoder.sv
// channel   dir  beat contents (lowest bits first)
// s_axis    in   tdata: sample[ADC_BITS], now_ms[32], zero fill to bytes
// m_axis    out  tdata: average[ADC_BITS], level[3], press_event[3], zero fill
// cfg       in   cfg_we / cfg_addr / cfg_data, one register write per cycle
//
// input beats are taken one per cycle while the two-group queue has room
// each completed group goes through the back end in turn: one load,
// ADC_BITS+8 steps of the restoring divider, one emit
// a stalled output holds the back end in its emit step; the front keeps
// summing until the queue fills, then drops s_axis_tready
// asynchronous reset restores the register defaults and clears control state
module adc_ladder_keypad_decoder #(
    parameter int ADC_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sample, now_ms
    input  logic [((ADC_BITS+akd_pkg::TIME_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // average, level, press_event
    output logic [((ADC_BITS+2*akd_pkg::CLS_W+7)/8)*8-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [akd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [akd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import akd_pkg::*;

    localparam int SUM_W  = ADC_BITS + SPG_W;
    localparam int GRP_W  = SUM_W + SPG_W + TIME_W;
    localparam int OUT_W  = ((ADC_BITS + 2*CLS_W + 7) / 8) * 8;

    logic [SPG_W-1:0] spg_reg;
    cls_cfg_t         cfg_reg;

    logic [ADC_BITS-1:0] sample;
    logic [TIME_W-1:0]   now_ms;
    logic                grp_push, grp_full, grp_pop, grp_empty;
    logic [SUM_W-1:0]    push_sum;
    logic [SPG_W-1:0]    push_count;
    logic [TIME_W-1:0]   push_time;
    logic [GRP_W-1:0]    fifo_wdata, fifo_rdata;
    logic [ADC_BITS-1:0] average;
    cls_t                level;
    cls_t                press_event;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spg_reg              <= RST_SPG;
            cfg_reg.right_limit  <= RST_RIGHT;
            cfg_reg.up_limit     <= RST_UP;
            cfg_reg.down_limit   <= RST_DOWN;
            cfg_reg.left_limit   <= RST_LEFT;
            cfg_reg.select_limit <= RST_SELECT;
            cfg_reg.settle_ms    <= RST_SETTLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SPG:    spg_reg              <= cfg_data[SPG_W-1:0];
                REG_RIGHT:  cfg_reg.right_limit  <= cfg_data[LIMIT_W-1:0];
                REG_UP:     cfg_reg.up_limit     <= cfg_data[LIMIT_W-1:0];
                REG_DOWN:   cfg_reg.down_limit   <= cfg_data[LIMIT_W-1:0];
                REG_LEFT:   cfg_reg.left_limit   <= cfg_data[LIMIT_W-1:0];
                REG_SELECT: cfg_reg.select_limit <= cfg_data[LIMIT_W-1:0];
                REG_SETTLE: cfg_reg.settle_ms    <= cfg_data[SETTLE_W-1:0];
                default:    ;
            endcase
        end
    end

    assign sample = s_axis_tdata[ADC_BITS-1:0];
    assign now_ms = s_axis_tdata[ADC_BITS+TIME_W-1:ADC_BITS];

    akd_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .samples_per_group (spg_reg),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .sample            (sample),
        .now_ms            (now_ms),
        .grp_push          (grp_push),
        .grp_full          (grp_full),
        .grp_sum           (push_sum),
        .grp_count         (push_count),
        .grp_time          (push_time)
    );

    assign fifo_wdata = {push_time, push_count, push_sum};

    akd_fifo #(
        .WIDTH (GRP_W)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (grp_push),
        .wdata (fifo_wdata),
        .full  (grp_full),
        .pop   (grp_pop),
        .rdata (fifo_rdata),
        .empty (grp_empty)
    );

    akd_back #(
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .grp_empty   (grp_empty),
        .grp_pop     (grp_pop),
        .grp_sum     (fifo_rdata[SUM_W-1:0]),
        .grp_count   (fifo_rdata[SUM_W+SPG_W-1:SUM_W]),
        .grp_time    (fifo_rdata[GRP_W-1:SUM_W+SPG_W]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .average     (average),
        .level       (level),
        .press_event (press_event)
    );

    assign m_axis_tdata = OUT_W'({press_event, level, average});

    // a press is only ever reported for the class of the same beat
    a_press_is_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && press_event != CLS_NONE) |-> (press_event == level))
        else $error("press event differs from level");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (level <= CLS_SELECT))
        else $error("level code out of range");

    // a queued group is never dropped: a full queue always stalls the input
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_full && !grp_pop) |=> grp_full)
        else $error("group queue lost an entry");

endmodule

### test/tb_top.sv
module tb_top;

    import akd_pkg::*;

    localparam int ADC_W        = 12;
    localparam int SUM_W        = 20;
    localparam int IN_W         = ((ADC_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_W        = ((ADC_W + 2 * CLS_W + 7) / 8) * 8;
    localparam int RANDOM_BEATS = 950;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 1000000;

    // no register lives at this index, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [ADC_W-1:0]  sample;
    } adc_beat_t;

    typedef struct {
        logic [ADC_W-1:0] average;
        cls_t             level;
        cls_t             press;
    } key_report_t;

    logic clk;
    logic rst_n = 1'b0;

    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // sample, now_ms, zero fill
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // average, level, press_event, zero fill
    logic [OUT_W-1:0] m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    adc_ladder_keypad_decoder #(
        .ADC_BITS(ADC_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    // decoder copy: register settings, group sum and debounce state
    logic [SPG_W-1:0]  group_size;
    cls_cfg_t          thr;
    logic [SUM_W-1:0]  run_sum;
    logic [SPG_W-1:0]  taken;
    cls_t              stable_lvl;
    cls_t              reported_lvl;
    logic [TIME_W-1:0] changed_at;

    adc_beat_t   sample_beats[$];
    adc_beat_t   beat_on_bus;
    key_report_t reports_due[$];
    int beats_queued = 0;
    int beats_taken = 0;
    int mismatches = 0;
    int cycles = 0;
    int src_gap = 0;
    int src_calm = 0;
    int sink_hold = 0;
    int sink_calm = 0;
    logic [TIME_W-1:0] clock_ms;

    logic [ADC_W-1:0] got_avg;
    cls_t             got_lvl;
    cls_t             got_press;
    key_report_t      want;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic cls_t level_of(input logic [ADC_W-1:0] avg);
        if (avg < thr.right_limit) return CLS_RIGHT;
        if (avg < thr.up_limit) return CLS_UP;
        if (avg < thr.down_limit) return CLS_DOWN;
        if (avg < thr.left_limit) return CLS_LEFT;
        if (avg < thr.select_limit) return CLS_SELECT;
        return CLS_NONE;
    endfunction

    function automatic void average_and_debounce(input logic [ADC_W-1:0] smp,
                                                 input logic [TIME_W-1:0] t);
        logic [SPG_W-1:0]  grp;
        logic [SPG_W:0]    cnt;
        logic [SUM_W-1:0]  quot;
        logic [TIME_W-1:0] held;
        cls_t              lvl;
        cls_t              press;
        key_report_t       rep;
        grp = (group_size == '0) ? SPG_W'(1) : group_size;
        run_sum = run_sum + SUM_W'(smp);
        cnt = taken + 1'b1;
        if (cnt < {1'b0, grp})
        begin
            taken = cnt[SPG_W-1:0];
            return;
        end
        // divisor is what was really summed, even if the group size shrank meanwhile
        quot = run_sum / SUM_W'(cnt);
        run_sum = '0;
        taken = '0;
        lvl = level_of(quot[ADC_W-1:0]);
        press = CLS_NONE;
        if (lvl != stable_lvl)
        begin
            stable_lvl = lvl;
            changed_at = t;
        end
        else
        begin
            held = t - changed_at;
            if (held >= TIME_W'(thr.settle_ms))
            begin
                if (stable_lvl != CLS_NONE && reported_lvl == CLS_NONE)
                    press = stable_lvl;
                reported_lvl = stable_lvl;
            end
        end
        rep.average = quot[ADC_W-1:0];
        rep.level = lvl;
        rep.press = press;
        reports_due.push_back(rep);
    endfunction

    // mostly short gaps, a few long ones, now and then a calm stretch with none
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_SPG:    group_size = val[SPG_W-1:0];
            REG_RIGHT:  thr.right_limit = val[LIMIT_W-1:0];
            REG_UP:     thr.up_limit = val[LIMIT_W-1:0];
            REG_DOWN:   thr.down_limit = val[LIMIT_W-1:0];
            REG_LEFT:   thr.left_limit = val[LIMIT_W-1:0];
            REG_SELECT: thr.select_limit = val[LIMIT_W-1:0];
            REG_SETTLE: thr.settle_ms = val[SETTLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_beat(input logic [ADC_W-1:0] smp, input logic [TIME_W-1:0] t);
        adc_beat_t b;
        b.sample = smp;
        b.now_ms = t;
        sample_beats.push_back(b);
        beats_queued++;
    endtask

    // a group still part-summed gives no result, so give the block time to take it in
    task automatic drain_results();
        while (beats_taken != beats_queued || reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // source side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                average_and_debounce(beat_on_bus.sample, beat_on_bus.now_ms);
                beats_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_beats.size() > 0)
                begin
                    beat_on_bus = sample_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= IN_W'(beat_on_bus);
                    src_gap = idle_len(src_calm);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_avg = m_axis_tdata[ADC_W-1:0];
                got_lvl = m_axis_tdata[ADC_W +: CLS_W];
                got_press = m_axis_tdata[ADC_W+CLS_W +: CLS_W];
                if (reports_due.size() == 0)
                begin
                    $display("%0t: result beat with none pending: average %0d level %0d press %0d",
                             $time, got_avg, got_lvl, got_press);
                    mismatches++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (got_avg !== want.average)
                    begin
                        $display("%0t: average expected %0d, got %0d",
                                 $time, want.average, got_avg);
                        mismatches++;
                    end
                    if (got_lvl !== want.level)
                    begin
                        $display("%0t: level expected %0d, got %0d",
                                 $time, want.level, got_lvl);
                        mismatches++;
                    end
                    if (got_press !== want.press)
                    begin
                        $display("%0t: press_event expected %0d, got %0d",
                                 $time, want.press, got_press);
                        mismatches++;
                    end
                end
            end
            if (sink_hold == 0 && $urandom_range(0, 3) == 0)
                sink_hold = idle_len(sink_calm);
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int random_beats;
        int phase_no;
        int pick;
        int spg;
        int grp;
        int settle;
        int tmax;
        int n;
        int hold;
        int base;
        int smp;
        int i;
        int k;
        int lims [5];

        group_size = RST_SPG;
        thr.right_limit = RST_RIGHT;
        thr.up_limit = RST_UP;
        thr.down_limit = RST_DOWN;
        thr.left_limit = RST_LEFT;
        thr.select_limit = RST_SELECT;
        thr.settle_ms = RST_SETTLE;
        run_sum = '0;
        taken = '0;
        stable_lvl = CLS_NONE;
        reported_lvl = CLS_NONE;
        changed_at = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default settings: one group of five, a zero then four full-scale samples, top of time
        queue_beat(12'd0, 32'd0);
        for (i = 0; i < 4; i++)
            queue_beat(12'hFFF, 32'hFFFF_FFFF);
        drain_results();

        // single-sample groups, no settle time: press, release, press again
        write_reg(REG_SPG, 16'd1);
        write_reg(REG_SETTLE, 16'd0);
        end_writes();
        queue_beat(12'hFFF, 32'd0);
        queue_beat(12'hFFF, 32'd1);
        queue_beat(12'd100, 32'd2);
        queue_beat(12'd100, 32'd2);
        queue_beat(12'd0, 32'd3);
        queue_beat(12'hFFF, 32'd4);
        queue_beat(12'hFFF, 32'd5);
        queue_beat(12'd1000, 32'd6);
        queue_beat(12'd1000, 32'd6);
        drain_results();

        // zero group size, longest settle measured across the time wrap
        write_reg(REG_SPG, 16'd0);
        write_reg(REG_SETTLE, 16'hFFFF);
        write_reg(REG_NONE, 16'hFFFF);
        end_writes();
        queue_beat(12'd2000, 32'hFFFF_FFF0);
        queue_beat(12'd2000, 32'h0000_FFEE);
        queue_beat(12'd2000, 32'h0000_FFEF);
        drain_results();

        // thresholds out of order, then the group size cut below what is summed
        write_reg(REG_RIGHT, 16'd0);
        write_reg(REG_UP, 16'hFFFF);
        write_reg(REG_DOWN, 16'd100);
        write_reg(REG_LEFT, 16'd0);
        write_reg(REG_SELECT, 16'hF000);
        write_reg(REG_SETTLE, 16'd0);
        write_reg(REG_SPG, 16'd5);
        end_writes();
        queue_beat(12'd50, 32'd10);
        queue_beat(12'd50, 32'd11);
        queue_beat(12'd50, 32'd12);
        drain_results();
        write_reg(REG_SPG, 16'd2);
        end_writes();
        queue_beat(12'd70, 32'd13);
        queue_beat(12'hFFF, 32'd14);
        queue_beat(12'hFFF, 32'd15);
        drain_results();

        random_beats = 0;
        phase_no = 0;
        clock_ms = $urandom;
        while (random_beats < RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 99);
            // the one largest group comes first, the rest stay small
            if (phase_no == 0) spg = 255;
            else if (pick < 6) spg = 0;
            else if (pick < 12) spg = $urandom_range(7, 40);
            else spg = $urandom_range(1, 6);

            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                lims[0] = RST_RIGHT;
                lims[1] = RST_UP;
                lims[2] = RST_DOWN;
                lims[3] = RST_LEFT;
                lims[4] = RST_SELECT;
            end
            else if (pick < 75)
            begin
                lims[0] = $urandom_range(0, 700);
                for (k = 1; k < 5; k++)
                begin
                    lims[k] = lims[k-1] + int'($urandom_range(0, 900));
                    if (lims[k] > 4095) lims[k] = 4095;
                end
            end
            else if (pick < 90)
            begin
                for (k = 0; k < 5; k++)
                    lims[k] = $urandom_range(0, 4095);
            end
            else
            begin
                for (k = 0; k < 5; k++)
                    lims[k] = ($urandom_range(0, 1) == 1) ? 4095 : 0;
            end

            pick = $urandom_range(0, 99);
            if (pick < 15) settle = 0;
            else if (pick < 25) settle = 65535;
            else settle = $urandom_range(1, 60);
            tmax = settle / 6 + 3;

            write_reg(REG_SPG, {8'($urandom_range(0, 255)), 8'(spg)});
            write_reg(REG_RIGHT, {4'($urandom_range(0, 15)), 12'(lims[0])});
            write_reg(REG_UP, {4'($urandom_range(0, 15)), 12'(lims[1])});
            write_reg(REG_DOWN, {4'($urandom_range(0, 15)), 12'(lims[2])});
            write_reg(REG_LEFT, {4'($urandom_range(0, 15)), 12'(lims[3])});
            write_reg(REG_SELECT, {4'($urandom_range(0, 15)), 12'(lims[4])});
            write_reg(REG_SETTLE, 16'(settle));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_NONE, 16'($urandom));
            end_writes();

            n = (phase_no == 0) ? 255 : $urandom_range(40, 120);
            grp = (spg == 0) ? 1 : spg;
            while (n > 0)
            begin
                // a key held for a few groups, a release, or a burst of noise
                pick = $urandom_range(0, 99);
                hold = grp * $urandom_range(1, 10);
                if (hold > n) hold = n;
                if (pick < 35) base = 4095 - int'($urandom_range(0, 3));
                else if (pick < 55) base = lims[$urandom_range(0, 4)];
                else base = $urandom_range(0, 4095);
                for (i = 0; i < hold; i++)
                begin
                    if (pick >= 88)
                    begin
                        smp = $urandom_range(0, 4095);
                        if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
                        else clock_ms = clock_ms + $urandom_range(0, tmax);
                    end
                    else
                    begin
                        smp = base + int'($urandom_range(0, 4)) - 2;
                        if (smp < 0) smp = 0;
                        if (smp > 4095) smp = 4095;
                        clock_ms = clock_ms + $urandom_range(0, tmax);
                    end
                    queue_beat(12'(smp), clock_ms);
                end
                n -= hold;
                random_beats += hold;
            end
            phase_no++;
            drain_results();
        end

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### adc_ladder_keypad_decoder.f
rtl/akd_pkg.sv
rtl/akd_front.sv
rtl/akd_fifo.sv
rtl/akd_back.sv
rtl/adc_ladder_keypad_decoder.sv
test/tb_top.sv
